FILE: src/pxt_pkg.sv
// ============================================================================
// pxt_pkg - shared types and constants of the persistent xor trie
// Node layout, item codes, pool limits and small helper functions.
// ============================================================================
package pxt_pkg;

    localparam int KEY_BITS   = 30;
    localparam int POOL_NODES = 65536;
    localparam int HANDLE_W   = 16;
    localparam int ADDR_W     = $clog2(POOL_NODES);
    localparam int HANDLE_MAX = (1 << HANDLE_W) - 1;
    localparam int LAST_NODE  = (POOL_NODES - 1 < HANDLE_MAX) ? POOL_NODES - 1 : HANDLE_MAX;
    localparam int LVL_W      = $clog2(KEY_BITS + 1);

    typedef logic [HANDLE_W-1:0] t_handle;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_QUERY  = 2'd1,
        FN_TRUNC  = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    // One trie node: the handles of its two children.
    typedef struct packed {
        t_handle zero;
        t_handle one;
    } t_node;

    // Write request from the walker to the node pool.
    typedef struct packed {
        logic    en;
        t_handle addr;
        t_node   data;
    } t_node_wr;

    // A handle past the pool reads as the empty trie.
    function automatic t_handle pool_index(input t_handle h);
        return ({1'b0, h} < 17'(POOL_NODES)) ? h : '0;
    endfunction

    // Truncate marks above the last usable node saturate to it.
    function automatic t_handle sat_mark(input t_handle m);
        return ({1'b0, m} > 17'(LAST_NODE)) ? HANDLE_W'(LAST_NODE) : m;
    endfunction

endpackage

FILE: src/pxt_node_mem.sv
// ============================================================================
// pxt_node_mem - node pool of the persistent xor trie
// One write port and one registered read port. Node zero is the null node
// and always reads as two null children; it is never written.
// ============================================================================
module pxt_node_mem import pxt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rd_en,
    input  t_handle  i_rd_addr,
    input  t_node_wr i_wr,
    output t_node    o_rd_data
);

    t_node r_mem [POOL_NODES];
    t_node r_q;
    logic  r_null;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr[ADDR_W-1:0]] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q    <= r_mem[i_rd_addr[ADDR_W-1:0]];
            r_null <= (i_rd_addr == '0);
        end
    end

    // The null node needs no reset pass: its read is masked to zero.
    assign o_rd_data = r_null ? '0 : r_q;

endmodule

FILE: src/persistent_xor_trie_core.sv
// ============================================================================
// persistent_xor_trie_core - persistent binary trie with max-xor queries
// Path-copying inserts, max-xor queries and pool truncation over one pool.
// ============================================================================
// Usage:
// The input channel (i_valid / o_ready) carries one word per item: a func
// code, a version root handle, a key and a pool mark. The output channel
// (o_valid / i_ready) returns one word per item: the result value, the pool
// top after the item and the pool-full flag.
// An insert walks the key from its top bit down, reading one node and
// writing one fresh copy per level, and a query reads one node per level.
// Each level passes through a read state and a use state, because the pool
// memory has a registered read port and the next address depends on the
// data just read. An insert walks KEY_BITS + 1 levels and a query KEY_BITS
// levels; a truncate, a refused insert or an unused code goes from the idle
// state straight to the done state. The block works on one item at a time.
// A finished word waits in the output register; the next item is accepted
// while it waits, and only the handoff of its own result stalls on i_ready.
// Reset clears the pool pointer and the control state. The pool memory is
// not cleared: the null node is masked on read, and every other node is
// written before any legal version can reach it.
// ============================================================================
module persistent_xor_trie_core import pxt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_version_root,
    input  logic [29:0] i_key,
    input  logic [15:0] i_pool_mark,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [29:0] o_result_value,
    output logic [15:0] o_pool_top,
    output logic        o_pool_full
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_USE  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state              r_state;
    t_handle             r_alloc;
    t_handle             r_src;
    t_handle             r_node;
    t_handle             r_top;
    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] r_val;
    logic [LVL_W-1:0]    r_lvl;
    logic                r_ins;
    t_node               r_hold;
    logic                r_fwd;
    logic [29:0]         r_res_value;
    t_handle             r_res_top;
    logic                r_res_full;
    logic                r_out_valid;
    logic [29:0]         r_out_value;
    t_handle             r_out_top;
    logic                r_out_full;

    t_node               mem_q;
    t_node               d;
    t_node               mod;
    t_node_wr            wr;
    logic                b;
    t_handle             child_b;
    t_handle             child_nb;
    t_handle             node_inc;
    logic                ins_last;
    logic                qry_last;
    logic                qbit;
    logic [KEY_BITS-1:0] n_val;
    logic                pool_short;

    pxt_node_mem u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (r_state == S_RD),
        .i_rd_addr (r_src),
        .i_wr      (wr),
        .o_rd_data (mem_q)
    );

    // When the child just fetched is the copy written one level up, the
    // walk must see that copy as it was before its child link was patched.
    assign d        = (r_ins && r_fwd) ? r_hold : mem_q;
    assign b        = r_key[KEY_BITS-1];
    assign child_b  = b ? d.one  : d.zero;
    assign child_nb = b ? d.zero : d.one;
    assign node_inc = r_node + 16'd1;
    assign ins_last = (r_lvl == LVL_W'(KEY_BITS));
    assign qry_last = (r_lvl == LVL_W'(KEY_BITS - 1));
    assign qbit     = (child_nb != '0);
    assign n_val    = (r_val << 1) | KEY_BITS'(qbit);

    // An insert needs KEY_BITS + 1 fresh nodes above the pointer.
    assign pool_short = ({1'b0, r_alloc} + 17'(KEY_BITS + 1)) > 17'(LAST_NODE);

    always_comb begin
        mod = d;
        if (b) begin
            mod.one = node_inc;
        end else begin
            mod.zero = node_inc;
        end
    end

    // Each level writes the fresh copy with its path link pointing at the
    // next fresh node; the leaf copy is written unchanged.
    assign wr.en   = (r_state == S_USE) && r_ins;
    assign wr.addr = r_node;
    assign wr.data = ins_last ? d : mod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_alloc     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In S_DONE the output register is refilled in the same cycle
            // that the old word leaves, so the flag is handled there.
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_key       <= KEY_BITS'(i_key);
                        r_val       <= '0;
                        r_lvl       <= '0;
                        r_fwd       <= 1'b0;
                        r_src       <= pool_index(i_version_root);
                        r_res_value <= '0;
                        // A refused insert and a truncate settle their word
                        // here; a finished insert fixes the pointer later.
                        r_res_full  <= (t_func'(i_func) == FN_INSERT) && pool_short;
                        r_res_top   <= (t_func'(i_func) == FN_TRUNC) ?
                                       sat_mark(i_pool_mark) : r_alloc;
                        r_ins       <= (t_func'(i_func) == FN_INSERT) && !pool_short;
                        case (t_func'(i_func))
                            FN_INSERT: begin
                                if (pool_short) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_top   <= r_alloc + 16'd1;
                                    r_node  <= r_alloc + 16'd1;
                                    r_state <= S_RD;
                                end
                            end
                            FN_QUERY: begin
                                r_state <= S_RD;
                            end
                            FN_TRUNC: begin
                                r_alloc <= sat_mark(i_pool_mark);
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_USE;
                end
                S_USE: begin
                    if (r_ins) begin
                        if (ins_last) begin
                            r_alloc     <= r_node;
                            r_res_top   <= r_node;
                            r_res_value <= 30'(r_top);
                            r_state     <= S_DONE;
                        end else begin
                            r_src   <= child_b;
                            r_hold  <= d;
                            r_fwd   <= (child_b == r_node);
                            r_node  <= node_inc;
                            r_key   <= r_key << 1;
                            r_lvl   <= r_lvl + LVL_W'(1);
                            r_state <= S_RD;
                        end
                    end else begin
                        r_val <= n_val;
                        r_src <= qbit ? child_nb : child_b;
                        r_key <= r_key << 1;
                        if (qry_last) begin
                            r_res_value <= 30'(n_val);
                            r_state     <= S_DONE;
                        end else begin
                            r_lvl   <= r_lvl + LVL_W'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_value <= r_res_value;
                        r_out_top   <= r_res_top;
                        r_out_full  <= r_res_full;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_pool_top     = r_out_top;
    assign o_pool_full    = r_out_full;

endmodule

FILE: src/pxt_checker.sv
// ============================================================================
// pxt_checker - port-level checks of the persistent xor trie
// Watches the channels of the top level over time; bound to it below.
// ============================================================================
module pxt_checker import pxt_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [1:0]  i_func,
    input logic [15:0] i_version_root,
    input logic [29:0] i_key,
    input logic [15:0] i_pool_mark,
    input logic        o_valid,
    input logic        i_ready,
    input logic [29:0] o_result_value,
    input logic [15:0] o_pool_top,
    input logic        o_pool_full
);

    // A stalled result word holds its place and its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_value)
            && $stable(o_pool_top) && $stable(o_pool_full))
        else $error("stalled result word changed");

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second item taken while busy");

    // A refused insert reports no root.
    a_full_no_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pool_full |-> o_result_value == '0)
        else $error("refused insert returned a root");

    // Nothing is offered right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word offered after reset");

endmodule

bind persistent_xor_trie_core pxt_checker u_pxt_checker (.*);
